### hdl/scp_pkg.sv
// Package with constants, types and character-class functions for the Set-Cookie header parser.
package scp_pkg;

	localparam int MaxHeaderBytes = 4096;
	localparam int MaxDirectives  = 8;
	localparam int PrefixLen      = 11;

	localparam logic [39:0] DeltaMax = 40'hFF_FFFF_FFFF;
	// Largest accumulator that can take one more digit (up to 5) without overflow.
	localparam logic [39:0] AgeTenth = 40'h19_9999_9999;

	typedef enum logic [3:0] {
		PH_PREFIX  = 4'd0,
		PH_NAME    = 4'd1,
		PH_VALUE   = 4'd2,
		PH_SEP     = 4'd3,
		PH_KEYWORD = 4'd4,
		PH_SKIP    = 4'd5,
		PH_AGE     = 4'd6,
		PH_DOMAIN  = 4'd7,
		PH_PATH    = 4'd8,
		PH_HALT    = 4'd9
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_SYNTAX      = 3'd1,
		ST_TOO_MANY    = 3'd2,
		ST_EXPIRES     = 3'd3,
		ST_NO_MAX_AGE  = 3'd4,
		ST_NO_DOMAIN   = 3'd5,
		ST_NO_PATH     = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		AGE_LEAD  = 2'd0,
		AGE_SIGN  = 2'd1,
		AGE_DIGIT = 2'd2,
		AGE_DONE  = 2'd3
	} age_sub_t;

	localparam int KW_EXPIRES  = 0;
	localparam int KW_MAX_AGE  = 1;
	localparam int KW_DOMAIN   = 2;
	localparam int KW_PATH     = 3;
	localparam int KW_SECURE   = 4;
	localparam int KW_HTTPONLY = 5;

	typedef struct packed {
		logic [2:0]  status;
		logic [11:0] name_start;
		logic [12:0] name_len;
		logic [11:0] value_start;
		logic [12:0] value_len;
		logic [11:0] domain_start;
		logic [12:0] domain_len;
		logic [11:0] path_start;
		logic [12:0] path_len;
		logic [40:0] expiry_seconds;
		logic [2:0]  attribute_flags;
		logic        path_present;
	} result_t;

	function automatic logic [7:0] prefix_char(input logic [3:0] idx);
		unique case (idx)
			4'd0: prefix_char = "S";
			4'd1: prefix_char = "e";
			4'd2: prefix_char = "t";
			4'd3: prefix_char = "-";
			4'd4: prefix_char = "C";
			4'd5: prefix_char = "o";
			4'd6: prefix_char = "o";
			4'd7: prefix_char = "k";
			4'd8: prefix_char = "i";
			4'd9: prefix_char = "e";
			4'd10: prefix_char = ":";
			default: prefix_char = 8'd0;
		endcase
	endfunction

	function automatic logic [3:0] kw_len(input int k);
		unique case (k)
			KW_EXPIRES, KW_MAX_AGE, KW_HTTPONLY: kw_len = 4'd8;
			KW_DOMAIN: kw_len = 4'd7;
			KW_PATH: kw_len = 4'd5;
			default: kw_len = 4'd6;
		endcase
	endfunction

	function automatic logic [7:0] kw_char(input int k, input logic [2:0] off);
		logic [63:0] s;
		s = 64'd0;
		unique case (k)
			KW_EXPIRES:  s = "=seripxe";
			KW_MAX_AGE:  s = "=ega-xam";
			KW_DOMAIN:   s = {8'd0, "=niamod"};
			KW_PATH:     s = {24'd0, "=htap"};
			KW_SECURE:   s = {16'd0, "eruces"};
			default:     s = "ylnoptth";
		endcase
		kw_char = s[{off, 3'b000} +: 8];
	endfunction

	function automatic logic is_token_byte(input logic [7:0] b);
		logic sep;
		sep = (b == "(") || (b == ")") || (b == "<") || (b == ">") || (b == "@") ||
			(b == ",") || (b == ";") || (b == ":") || (b == "\\") || (b == "\"") ||
			(b == "/") || (b == "[") || (b == "]") || (b == "?") || (b == "=") ||
			(b == "{") || (b == "}") || (b == " ") || (b == 8'd9);
		is_token_byte = !(b <= 8'd31 || b == 8'd127 || sep);
	endfunction

	function automatic logic is_octet(input logic [7:0] b);
		is_octet = (b == 8'h21) || (b >= 8'h23 && b <= 8'h2b) || (b >= 8'h2d && b <= 8'h3a) ||
			(b >= 8'h3c && b <= 8'h5b) || (b >= 8'h5d && b <= 8'h7e);
	endfunction

	function automatic logic [7:0] fold(input logic [7:0] b);
		fold = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
	endfunction

endpackage

### hdl/scp_if.sv
// Valid/ready channel interface for the Set-Cookie header parser.
interface scp_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  header_byte;
	logic        end_of_header;
	logic [39:0] now_seconds;
	modport source (output valid, header_byte, end_of_header, now_seconds, input ready);
	modport sink (input valid, header_byte, end_of_header, now_seconds, output ready);
endinterface

interface scp_out_if;
	logic              valid;
	logic              ready;
	scp_pkg::result_t  result;
	modport source (output valid, result, input ready);
	modport sink (input valid, result, output ready);
endinterface

### hdl/set_cookie_header_parser_core.sv
// Top level of the Set-Cookie header parser: byte-serial scan and one result per header.
//
//  channel  | dir | payload                                   | handshake
//  ---------+-----+-------------------------------------------+------------
//  hdr      | in  | header_byte, end_of_header, now_seconds   | valid/ready
//  res      | out | result_t: status, bounds, expiry, flags   | valid/ready
//
// One header byte is taken per cycle unless the input side stalls. The byte
// first lands in an input register; the parse state is then updated from it
// and, on the final byte, the result register is loaded. The result is valid
// once the final byte has passed the input register and the result register.
// The input side stalls only while the result register is full, not taken
// and a new result is about to be written.
// The asynchronous reset clears the handshake state and the parse state.
module set_cookie_header_parser_core #(
	parameter int MAX_HEADER_BYTES = scp_pkg::MaxHeaderBytes,
	parameter int MAX_DIRECTIVES   = scp_pkg::MaxDirectives
) (
	input  logic clk,
	input  logic arst_n,
	scp_in_if.sink    hdr,
	scp_out_if.source res
);

	localparam int PosW = $clog2(MAX_HEADER_BYTES + 2);
	localparam int DirW = $clog2(MAX_DIRECTIVES + 1);

	// Input register stage.
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic [39:0] now_s1;

	// The stage-1 item can always advance unless it is final and the output is blocked.
	logic out_free;
	logic adv_s1;
	assign out_free = !res.valid || res.ready;
	assign adv_s1   = valid_s1 && (!last_s1 || out_free);
	assign hdr.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (hdr.ready) begin
			valid_s1 <= hdr.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (hdr.ready && hdr.valid) begin
			byte_s1 <= hdr.header_byte;
			last_s1 <= hdr.end_of_header;
			now_s1  <= hdr.now_seconds;
		end
	end

	// Parse state.
	scp_pkg::phase_t   phase_q;
	logic [PosW-1:0]   pos_q;
	logic [3:0]        pidx_q;
	logic [DirW-1:0]   dcnt_q;
	logic [5:0]        cand_q;
	logic [3:0]        koff_q;
	logic [1:0]        serr_q;
	logic              ended_q;
	logic [12:0]       nlen_q;
	logic [11:0]       vstart_q;
	logic [12:0]       vlen_q;
	logic [7:0]        vfirst_q, vlast_q;
	logic [11:0]       dstart_q;
	logic [12:0]       dlen_q;
	logic [7:0]        dfirst_q;
	logic [11:0]       pstart_q;
	logic [12:0]       plen_q;
	logic [39:0]       age_q;
	logic              neg_q;
	scp_pkg::age_sub_t asub_q;
	logic [5:0]        seen_q;
	logic [1:0]        chk_q;

	// Next-state values.
	scp_pkg::phase_t   phase_d;
	logic [PosW-1:0]   pos_d;
	logic [3:0]        pidx_d;
	logic [DirW-1:0]   dcnt_d;
	logic [5:0]        cand_d;
	logic [3:0]        koff_d;
	logic [1:0]        serr_d;
	logic              ended_d;
	logic [12:0]       nlen_d;
	logic [11:0]       vstart_d;
	logic [12:0]       vlen_d;
	logic [7:0]        vfirst_d, vlast_d;
	logic [11:0]       dstart_d;
	logic [12:0]       dlen_d;
	logic [7:0]        dfirst_d;
	logic [11:0]       pstart_d;
	logic [12:0]       plen_d;
	logic [39:0]       age_d;
	logic              neg_d;
	scp_pkg::age_sub_t asub_d;
	logic [5:0]        seen_d;
	logic [1:0]        chk_d;

	logic [7:0]  b;
	logic [11:0] p1;
	logic [5:0]  cand_m;
	logic [3:0]  koff_n;
	logic        hit;
	int          hit_k;
	logic [39:0] age_mul;
	logic [3:0]  dig;
	logic        consume;
	logic        too_long;

	assign b  = byte_s1;
	assign p1 = 12'(pos_q) + 12'd1;
	assign dig = b[3:0];
	assign age_mul = (age_q << 3) + (age_q << 1) + {36'd0, dig};

	// Keyword candidate filtering runs over the six keywords in parallel.
	always_comb begin
		cand_m = cand_q;
		for (int k = 0; k < 6; k++) begin
			if (cand_q[k] && (koff_q >= scp_pkg::kw_len(k) ||
				scp_pkg::fold(b) != scp_pkg::kw_char(k, koff_q[2:0]))) begin
				cand_m[k] = 1'b0;
			end
		end
		koff_n = koff_q + 4'd1;
		hit = 1'b0;
		hit_k = 0;
		for (int k = 5; k >= 0; k--) begin
			if (cand_m[k] && scp_pkg::kw_len(k) == koff_n) begin
				hit = 1'b1;
				hit_k = k;
			end
		end
	end

	always_comb begin
		phase_d = phase_q; pos_d = pos_q; pidx_d = pidx_q; dcnt_d = dcnt_q;
		cand_d = cand_q; koff_d = koff_q; serr_d = serr_q; ended_d = ended_q;
		nlen_d = nlen_q; vstart_d = vstart_q; vlen_d = vlen_q;
		vfirst_d = vfirst_q; vlast_d = vlast_q;
		dstart_d = dstart_q; dlen_d = dlen_q; dfirst_d = dfirst_q;
		pstart_d = pstart_q; plen_d = plen_q;
		age_d = age_q; neg_d = neg_q; asub_d = asub_q;
		seen_d = seen_q; chk_d = chk_q;
		too_long = pos_q >= PosW'(MAX_HEADER_BYTES);
		consume = !too_long && !ended_q && b != 8'd0;

		if (too_long) begin
			pos_d = PosW'(MAX_HEADER_BYTES + 1);
		end else begin
			pos_d = pos_q + PosW'(1);
			if (!ended_q && b == 8'd0) ended_d = 1'b1;
		end

		if (consume) begin
			unique case (phase_q)
				scp_pkg::PH_PREFIX: begin
					if (pidx_q < 4'(scp_pkg::PrefixLen)) begin
						if (b != scp_pkg::prefix_char(pidx_q)) begin
							if (serr_q == 2'd0) serr_d = 2'(scp_pkg::ST_SYNTAX);
							phase_d = scp_pkg::PH_HALT;
						end else begin
							pidx_d = pidx_q + 4'd1;
						end
					end else if (b != " ") begin
						if (serr_q == 2'd0) serr_d = 2'(scp_pkg::ST_SYNTAX);
						phase_d = scp_pkg::PH_HALT;
					end else begin
						phase_d = scp_pkg::PH_NAME;
					end
				end
				scp_pkg::PH_NAME: begin
					if (b == "=") begin
						phase_d = scp_pkg::PH_VALUE;
						vstart_d = p1;
					end else begin
						nlen_d = nlen_q + 13'd1;
						if (!scp_pkg::is_token_byte(b)) chk_d[0] = 1'b0;
					end
				end
				scp_pkg::PH_VALUE: begin
					if (b == ";") begin
						phase_d = scp_pkg::PH_SEP;
					end else begin
						if (vlen_q == 13'd0) vfirst_d = b;
						else if (vlen_q >= 13'd2 && !scp_pkg::is_octet(vlast_q)) chk_d[1] = 1'b0;
						vlast_d = b;
						vlen_d = vlen_q + 13'd1;
					end
				end
				scp_pkg::PH_SEP: begin
					if (b != " ") begin
						if (serr_q == 2'd0) serr_d = 2'(scp_pkg::ST_SYNTAX);
						phase_d = scp_pkg::PH_HALT;
					end else if (dcnt_q >= DirW'(MAX_DIRECTIVES)) begin
						if (serr_q == 2'd0) serr_d = 2'(scp_pkg::ST_TOO_MANY);
						phase_d = scp_pkg::PH_HALT;
					end else begin
						dcnt_d = dcnt_q + DirW'(1);
						cand_d = 6'h3F;
						koff_d = 4'd0;
						phase_d = scp_pkg::PH_KEYWORD;
					end
				end
				scp_pkg::PH_KEYWORD: begin
					if (b == ";") begin
						phase_d = scp_pkg::PH_SEP;
					end else begin
						cand_d = cand_m;
						// The offset stops growing one past the longest keyword; nothing matches there.
						koff_d = (koff_q == 4'd9) ? koff_q : koff_n;
						if (cand_m == 6'd0) begin
							phase_d = scp_pkg::PH_SKIP;
						end else if (hit) begin
							phase_d = scp_pkg::PH_SKIP;
							unique case (hit_k)
								scp_pkg::KW_EXPIRES: seen_d[0] = 1'b1;
								scp_pkg::KW_MAX_AGE: begin
									if (!seen_q[1]) begin
										seen_d[1] = 1'b1;
										age_d = 40'd0; neg_d = 1'b0;
										asub_d = scp_pkg::AGE_LEAD;
										phase_d = scp_pkg::PH_AGE;
									end
								end
								scp_pkg::KW_DOMAIN: begin
									if (!seen_q[2]) begin
										seen_d[2] = 1'b1;
										dstart_d = p1; dlen_d = 13'd0; dfirst_d = 8'd0;
										phase_d = scp_pkg::PH_DOMAIN;
									end
								end
								scp_pkg::KW_PATH: begin
									if (!seen_q[3]) begin
										seen_d[3] = 1'b1;
										pstart_d = p1; plen_d = 13'd0;
										phase_d = scp_pkg::PH_PATH;
									end
								end
								scp_pkg::KW_SECURE: seen_d[4] = 1'b1;
								default: seen_d[5] = 1'b1;
							endcase
						end
					end
				end
				scp_pkg::PH_AGE: begin
					if (b == ";") begin
						phase_d = scp_pkg::PH_SEP;
					end else if (asub_q == scp_pkg::AGE_LEAD &&
						((b >= 8'd9 && b <= 8'd13) || b == 8'd32)) begin
						asub_d = asub_q;
					end else if (asub_q == scp_pkg::AGE_LEAD && (b == "+" || b == "-")) begin
						neg_d = (b == "-");
						asub_d = scp_pkg::AGE_SIGN;
					end else if (asub_q != scp_pkg::AGE_DONE && b >= "0" && b <= "9") begin
						// Saturate when value*10+d would exceed 2^40-1.
						if (age_q > scp_pkg::AgeTenth ||
							(age_q == scp_pkg::AgeTenth && dig > 4'd5)) begin
							age_d = scp_pkg::DeltaMax;
						end else begin
							age_d = age_mul;
						end
						asub_d = scp_pkg::AGE_DIGIT;
					end else begin
						asub_d = scp_pkg::AGE_DONE;
					end
				end
				scp_pkg::PH_DOMAIN: begin
					if (b == ";") begin
						phase_d = scp_pkg::PH_SEP;
					end else begin
						if (dlen_q == 13'd0) dfirst_d = b;
						dlen_d = dlen_q + 13'd1;
					end
				end
				scp_pkg::PH_PATH: begin
					if (b == ";") phase_d = scp_pkg::PH_SEP;
					else plen_d = plen_q + 13'd1;
				end
				scp_pkg::PH_SKIP: begin
					if (b == ";") phase_d = scp_pkg::PH_SEP;
				end
				default: begin
					phase_d = phase_q;
				end
			endcase
		end
	end

	// Result computation on the final byte, from the updated state.
	scp_pkg::result_t r;
	logic        vok;
	logic [11:0] vs;
	logic [12:0] vl;
	logic [1:0]  serr_f;
	scp_pkg::status_t st;

	always_comb begin
		serr_f = serr_d;
		if ((phase_d == scp_pkg::PH_PREFIX || phase_d == scp_pkg::PH_NAME ||
			phase_d == scp_pkg::PH_SEP) && serr_d == 2'd0) begin
			serr_f = 2'(scp_pkg::ST_SYNTAX);
		end
		vs = 12'd0;
		vl = 13'd0;
		if (vlen_d == 13'd0) begin
			vok = 1'b0;
		end else if (vfirst_d == "\"") begin
			vok = vlen_d >= 13'd3 && vlast_d == "\"" && chk_d[1];
			vs = vstart_d + 12'd1;
			vl = vlen_d - 13'd2;
		end else begin
			vok = scp_pkg::is_octet(vfirst_d) &&
				(vlen_d == 13'd1 || (chk_d[1] && scp_pkg::is_octet(vlast_d)));
			vs = vstart_d;
			vl = vlen_d;
		end
		priority if (pos_d > PosW'(MAX_HEADER_BYTES)) st = scp_pkg::ST_SYNTAX;
		else if (serr_f == 2'(scp_pkg::ST_TOO_MANY)) st = scp_pkg::ST_TOO_MANY;
		else if (serr_f != 2'd0) st = scp_pkg::ST_SYNTAX;
		else if (nlen_d == 13'd0 || !chk_d[0]) st = scp_pkg::ST_SYNTAX;
		else if (!vok) st = scp_pkg::ST_SYNTAX;
		else if (!seen_d[1]) st = seen_d[0] ? scp_pkg::ST_EXPIRES : scp_pkg::ST_NO_MAX_AGE;
		else if (!seen_d[2] || dlen_d == 13'd0) st = scp_pkg::ST_NO_DOMAIN;
		else if (!seen_d[3]) st = scp_pkg::ST_NO_PATH;
		else st = scp_pkg::ST_OK;

		r = '0;
		r.status = st;
		if (st == scp_pkg::ST_OK) begin
			r.name_start = 12'(scp_pkg::PrefixLen + 1);
			r.name_len = nlen_d;
			r.value_start = vs;
			r.value_len = vl;
			r.domain_start = dstart_d;
			r.domain_len = dlen_d;
			r.path_start = pstart_d;
			r.path_len = plen_d;
			r.expiry_seconds = (!neg_d && age_d != 40'd0) ?
				({1'b0, now_s1} + {1'b0, age_d}) : 41'd0;
			r.attribute_flags = {dfirst_d == ".", seen_d[5], seen_d[4]};
			r.path_present = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= scp_pkg::PH_PREFIX; pos_q <= '0; pidx_q <= '0; dcnt_q <= '0;
			cand_q <= 6'h3F; koff_q <= '0; serr_q <= '0; ended_q <= 1'b0;
			nlen_q <= '0; vstart_q <= '0; vlen_q <= '0; vfirst_q <= '0; vlast_q <= '0;
			dstart_q <= '0; dlen_q <= '0; dfirst_q <= '0; pstart_q <= '0; plen_q <= '0;
			age_q <= '0; neg_q <= 1'b0; asub_q <= scp_pkg::AGE_LEAD;
			seen_q <= '0; chk_q <= 2'b11;
		end else if (adv_s1) begin
			if (last_s1) begin
				phase_q <= scp_pkg::PH_PREFIX; pos_q <= '0; pidx_q <= '0; dcnt_q <= '0;
				cand_q <= 6'h3F; koff_q <= '0; serr_q <= '0; ended_q <= 1'b0;
				nlen_q <= '0; vstart_q <= '0; vlen_q <= '0; vfirst_q <= '0; vlast_q <= '0;
				dstart_q <= '0; dlen_q <= '0; dfirst_q <= '0; pstart_q <= '0; plen_q <= '0;
				age_q <= '0; neg_q <= 1'b0; asub_q <= scp_pkg::AGE_LEAD;
				seen_q <= '0; chk_q <= 2'b11;
			end else begin
				phase_q <= phase_d; pos_q <= pos_d; pidx_q <= pidx_d; dcnt_q <= dcnt_d;
				cand_q <= cand_d; koff_q <= koff_d; serr_q <= serr_d; ended_q <= ended_d;
				nlen_q <= nlen_d; vstart_q <= vstart_d; vlen_q <= vlen_d;
				vfirst_q <= vfirst_d; vlast_q <= vlast_d;
				dstart_q <= dstart_d; dlen_q <= dlen_d; dfirst_q <= dfirst_d;
				pstart_q <= pstart_d; plen_q <= plen_d;
				age_q <= age_d; neg_q <= neg_d; asub_q <= asub_d;
				seen_q <= seen_d; chk_q <= chk_d;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.valid <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			res.valid <= 1'b1;
		end else if (res.ready) begin
			res.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) res.result <= r;
	end

endmodule
